// ===== hw/rtl/mag_hard_iron_calibrator_assert.svh =====
// Assertion macros for the magnetometer hard-iron calibrator.
`ifndef MAG_HARD_IRON_CALIBRATOR_ASSERT_SVH
`define MAG_HARD_IRON_CALIBRATOR_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define MHIC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define MHIC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/mhic_pkg.sv =====
// Constants shared by the magnetometer hard-iron calibrator.
`timescale 1ns / 1ps
package mhic_pkg;

  // Filter factor is a Q0.16 fraction
  localparam int unsigned FACTOR_BITS = 16;
  // Sample counter and warm-up register width
  localparam int unsigned CNT_BITS    = 16;
  // Widest configuration register
  localparam int unsigned CFG_DATA_BITS = 16;
  localparam int unsigned CFG_IDX_BITS  = 1;
  localparam int unsigned NUM_AXES      = 3;

  // Configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_FILTER_FACTOR = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] REG_WARMUP_COUNT  = 1'b1;

  // Reset values of the configuration registers
  localparam logic [FACTOR_BITS-1:0] FILTER_FACTOR_RST = 16'd58982;
  localparam logic [CNT_BITS-1:0]    WARMUP_COUNT_RST  = 16'd100;

endpackage

// ===== hw/rtl/mag_hard_iron_calibrator.sv =====
// Magnetometer hard-iron calibrator: low-pass filter and min/max bias tracking.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one three-axis sample per beat.
//   Output channel (out_valid_o/out_ready_i) returns one result beat per sample:
//   tracking flag plus per-axis min, max and bias (all zero until tracking).
//   Configuration: cfg_we_i writes cfg_wdata_i into the register at cfg_idx_i
//   (0 = filter factor, 1 = warm-up count). Write only while the block is idle.
// Timing:
//   Three register stages: input, filtered state, result. One sample per
//   cycle sustained while out_ready_i is high. The critical path is the
//   filter update: subtract, 17 x 33 multiply, add.
// Reset:
//   Filter state, sample counter and tracking flag clear; min/max preset to
//   state max/min; configuration registers return to 0.9 (Q0.16) and 100.
// Stall:
//   A held result blocks only its own stage; the stage behind it and the input
//   register still fill, so up to two more samples are taken before in_ready_o
//   drops.
`timescale 1ns / 1ps
module mag_hard_iron_calibrator #(
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned FRAC_BITS   = 16
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // configuration write port
  input  logic                                   cfg_we_i,
  input  logic [mhic_pkg::CFG_IDX_BITS-1:0]      cfg_idx_i,
  input  logic [mhic_pkg::CFG_DATA_BITS-1:0]     cfg_wdata_i,
  // sample channel
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0]          mag_x_i,
  input  logic signed [SAMPLE_BITS-1:0]          mag_y_i,
  input  logic signed [SAMPLE_BITS-1:0]          mag_z_i,
  // result channel
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic                                   tracking_valid_o,
  output logic signed [SAMPLE_BITS-1:0]          low_x_o,
  output logic signed [SAMPLE_BITS-1:0]          high_x_o,
  output logic signed [SAMPLE_BITS-1:0]          offset_x_o,
  output logic signed [SAMPLE_BITS-1:0]          low_y_o,
  output logic signed [SAMPLE_BITS-1:0]          high_y_o,
  output logic signed [SAMPLE_BITS-1:0]          offset_y_o,
  output logic signed [SAMPLE_BITS-1:0]          low_z_o,
  output logic signed [SAMPLE_BITS-1:0]          high_z_o,
  output logic signed [SAMPLE_BITS-1:0]          offset_z_o
);
  import mhic_pkg::*;

  localparam int unsigned StateW = SAMPLE_BITS + FRAC_BITS;
  localparam int unsigned DiffW  = StateW + 1;
  localparam int unsigned ProdW  = FACTOR_BITS + 1 + DiffW;
  localparam int unsigned ScaleW = ProdW - FACTOR_BITS;

  localparam logic signed [StateW-1:0] StateMax = {1'b0, {(StateW-1){1'b1}}};
  localparam logic signed [StateW-1:0] StateMin = {1'b1, {(StateW-1){1'b0}}};

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [StateW-1:0]      state_t;

  // configuration registers
  logic [FACTOR_BITS-1:0] factor_q;
  logic [CNT_BITS-1:0]    warmup_q;

  // pipeline handshake
  logic s1_valid_q, s2_valid_q, out_valid_q;
  logic s1_adv, s2_adv, s2_free;

  // stage registers and state
  sample_t               s1_mag_q [NUM_AXES];
  state_t                s2_f_q   [NUM_AXES];
  logic                  s2_track_q;
  state_t                smooth_q [NUM_AXES];
  state_t                smooth_d [NUM_AXES];
  state_t                min_q    [NUM_AXES];
  state_t                min_d    [NUM_AXES];
  state_t                max_q    [NUM_AXES];
  state_t                max_d    [NUM_AXES];
  logic [CNT_BITS-1:0]   cnt_q, cnt_d, cnt_inc;
  logic                  track_d;
  logic                  valid_q, valid_d;

  // result registers
  sample_t               lo_q   [NUM_AXES];
  sample_t               hi_q   [NUM_AXES];
  sample_t               bias_q [NUM_AXES];
  sample_t               lo_d   [NUM_AXES];
  sample_t               hi_d   [NUM_AXES];
  sample_t               bias_d [NUM_AXES];

  // Stage advance: each stage moves when the one ahead is empty or moving
  assign s2_adv     = s2_valid_q && (!out_valid_q || out_ready_i);
  assign s2_free    = !s2_valid_q || s2_adv;
  assign s1_adv     = s1_valid_q && s2_free;
  assign in_ready_o = !s1_valid_q || s2_free;

  // Configuration write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      factor_q <= FILTER_FACTOR_RST;
      warmup_q <= WARMUP_COUNT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_FILTER_FACTOR: factor_q <= cfg_wdata_i[FACTOR_BITS-1:0];
        REG_WARMUP_COUNT:  warmup_q <= cfg_wdata_i[CNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Filter update: f' = xs + floor(a * (f - xs) / 2^16); the first sample loads f = xs
  always_comb begin
    state_t                   xs;
    logic signed [DiffW-1:0]  diff;
    logic signed [ProdW-1:0]  prod;
    logic signed [ScaleW-1:0] sum;
    cnt_inc = (cnt_q < warmup_q) ? cnt_q + 1'b1 : cnt_q;
    if (cnt_q == '0) begin
      cnt_d   = CNT_BITS'(1);
      track_d = 1'b0;
    end else begin
      cnt_d   = cnt_inc;
      track_d = (cnt_inc >= warmup_q);
    end
    for (int i = 0; i < NUM_AXES; i++) begin
      xs   = {s1_mag_q[i], {FRAC_BITS{1'b0}}};
      diff = DiffW'(smooth_q[i]) - DiffW'(xs);
      prod = ProdW'($signed({1'b0, factor_q})) * ProdW'(diff);
      sum  = prod[ProdW-1:FACTOR_BITS] + ScaleW'(xs);
      smooth_d[i] = (cnt_q == '0) ? xs : sum[StateW-1:0];
    end
  end

  // Min/max tracking and result formatting
  always_comb begin
    logic signed [SAMPLE_BITS:0] pair_sum;
    valid_d = valid_q || s2_track_q;
    for (int i = 0; i < NUM_AXES; i++) begin
      min_d[i] = (s2_track_q && (s2_f_q[i] < min_q[i])) ? s2_f_q[i] : min_q[i];
      max_d[i] = (s2_track_q && (s2_f_q[i] > max_q[i])) ? s2_f_q[i] : max_q[i];
      pair_sum = (SAMPLE_BITS+1)'(sample_t'(min_d[i][StateW-1 -: SAMPLE_BITS]))
               + (SAMPLE_BITS+1)'(sample_t'(max_d[i][StateW-1 -: SAMPLE_BITS]));
      if (valid_d) begin
        lo_d[i]   = min_d[i][StateW-1 -: SAMPLE_BITS];
        hi_d[i]   = max_d[i][StateW-1 -: SAMPLE_BITS];
        bias_d[i] = pair_sum[SAMPLE_BITS:1];
      end else begin
        lo_d[i]   = '0;
        hi_d[i]   = '0;
        bias_d[i] = '0;
      end
    end
  end

  // Valid flags of the three stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) s1_valid_q <= in_valid_i;
      if (s2_free)    s2_valid_q <= s1_adv;
      if (!out_valid_q || out_ready_i) out_valid_q <= s2_valid_q;
    end
  end

  // Input register
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_mag_q[0] <= mag_x_i;
      s1_mag_q[1] <= mag_y_i;
      s1_mag_q[2] <= mag_z_i;
    end
  end

  // Filter state and counter, updated as a beat leaves the input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      s2_track_q <= 1'b0;
      for (int i = 0; i < NUM_AXES; i++) begin
        smooth_q[i] <= '0;
        s2_f_q[i]   <= '0;
      end
    end else if (s1_adv) begin
      cnt_q      <= cnt_d;
      s2_track_q <= track_d;
      for (int i = 0; i < NUM_AXES; i++) begin
        smooth_q[i] <= smooth_d[i];
        s2_f_q[i]   <= smooth_d[i];
      end
    end
  end

  // Extremes and tracking flag, updated as a beat enters the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      for (int i = 0; i < NUM_AXES; i++) begin
        min_q[i] <= StateMax;
        max_q[i] <= StateMin;
      end
    end else if (s2_adv) begin
      valid_q <= valid_d;
      for (int i = 0; i < NUM_AXES; i++) begin
        min_q[i] <= min_d[i];
        max_q[i] <= max_d[i];
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (s2_adv) begin
      tracking_valid_o <= valid_d;
      for (int i = 0; i < NUM_AXES; i++) begin
        lo_q[i]   <= lo_d[i];
        hi_q[i]   <= hi_d[i];
        bias_q[i] <= bias_d[i];
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign low_x_o     = lo_q[0];
  assign high_x_o    = hi_q[0];
  assign offset_x_o  = bias_q[0];
  assign low_y_o     = lo_q[1];
  assign high_y_o    = hi_q[1];
  assign offset_y_o  = bias_q[1];
  assign low_z_o     = lo_q[2];
  assign high_z_o    = hi_q[2];
  assign offset_z_o  = bias_q[2];

  `include "mag_hard_iron_calibrator_assert.svh"

  // Once tracking starts it never stops
  `MHIC_ASSERT_NEXT(a_track_sticky, valid_q, valid_q, "tracking flag dropped")
  // Tracking means the X-axis extremes are ordered
  `MHIC_ASSERT_NOW(a_min_le_max, valid_q, min_q[0] <= max_q[0], "min above max")
  // A tracking beat only follows a loaded filter
  `MHIC_ASSERT_NOW(a_track_loaded, s2_valid_q && s2_track_q, cnt_q != '0,
                   "tracking before first sample")
  // Results before tracking are zero on the X axis
  `MHIC_ASSERT_NOW(a_zero_untracked, out_valid_q && !tracking_valid_o,
                   (lo_q[0] == '0) && (hi_q[0] == '0) && (bias_q[0] == '0),
                   "nonzero result while not tracking")

endmodule

// ===== dv/tb_mag_hard_iron_calibrator.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the magnetometer hard-iron calibrator.
module tb_mag_hard_iron_calibrator;
  import mhic_pkg::*;

  localparam int unsigned AXIS_BITS   = 16;
  localparam int unsigned FRAC_SHIFT  = 16;
  localparam int unsigned PHASES      = 10;
  localparam int unsigned PHASE_BEATS = 170;
  localparam int unsigned MAX_GAP     = 11;
  localparam int unsigned HOLD_CYCLES = 150;
  localparam int unsigned PRINT_CAP   = 100;
  localparam longint      STATE_MAX   = 64'sd2147483647;
  localparam longint      STATE_MIN   = -64'sd2147483648;
  localparam longint      LIMIT_NS    = 2_000_000;

  typedef logic [NUM_AXES-1:0][AXIS_BITS-1:0] axis_triple_t;

  // one result beat, axis 0 is X
  typedef struct packed {
    logic         tracking;
    axis_triple_t low;
    axis_triple_t high;
    axis_triple_t offset;
  } cal_result_t;

  typedef enum logic [1:0] {
    ROW_SAMPLE,
    ROW_CHECKED,
    ROW_CFG
  } row_kind_e;

  typedef struct packed {
    row_kind_e                 kind;
    logic [CFG_IDX_BITS-1:0]   reg_idx;
    logic [CFG_DATA_BITS-1:0]  reg_data;
    axis_triple_t              sample;
    cal_result_t               want;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_BITS-1:0] cfg_idx_i;
  logic [CFG_DATA_BITS-1:0] cfg_wdata_i;
  logic in_valid_i;
  logic in_ready_o;
  logic signed [AXIS_BITS-1:0] mag_x_i, mag_y_i, mag_z_i;
  logic out_valid_o;
  logic out_ready_i;
  logic tracking_valid_o;
  logic signed [AXIS_BITS-1:0] low_x_o, high_x_o, offset_x_o;
  logic signed [AXIS_BITS-1:0] low_y_o, high_y_o, offset_y_o;
  logic signed [AXIS_BITS-1:0] low_z_o, high_z_o, offset_z_o;

  // shared between the sample and result processes
  bit          link_busy;
  bit          hold_req;
  int unsigned mismatch_cnt;
  cal_result_t pending_results [$];

  // calibrator state mirror
  longint                 smooth_q [NUM_AXES];
  longint                 min_q [NUM_AXES];
  longint                 max_q [NUM_AXES];
  logic [CNT_BITS-1:0]    sample_cnt;
  logic [FACTOR_BITS-1:0] factor_q;
  logic [CNT_BITS-1:0]    warmup_q;

  mag_hard_iron_calibrator i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .mag_x_i          (mag_x_i),
    .mag_y_i          (mag_y_i),
    .mag_z_i          (mag_z_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .tracking_valid_o (tracking_valid_o),
    .low_x_o          (low_x_o),
    .high_x_o         (high_x_o),
    .offset_x_o       (offset_x_o),
    .low_y_o          (low_y_o),
    .high_y_o         (high_y_o),
    .offset_y_o       (offset_y_o),
    .low_z_o          (low_z_o),
    .high_z_o         (high_z_o),
    .offset_z_o       (offset_z_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Filter, warm-up and min/max update for one sample; returns the result beat
  function automatic cal_result_t advance_calibrator(input axis_triple_t s);
    cal_result_t r;
    longint      a;
    longint      xs;
    longint      lo;
    longint      hi;
    longint      bias;
    r = '0;
    a = longint'(factor_q);
    if (sample_cnt == '0) begin
      // first sample seeds the filter, nothing tracked
      for (int i = 0; i < NUM_AXES; i++) smooth_q[i] = longint'($signed(s[i])) * 65536;
      sample_cnt = CNT_BITS'(1);
    end else begin
      if (sample_cnt < warmup_q) sample_cnt = sample_cnt + 1'b1;
      for (int i = 0; i < NUM_AXES; i++) begin
        xs = longint'($signed(s[i])) * 65536;
        smooth_q[i] = (a * smooth_q[i] + (65536 - a) * xs) >>> FRAC_SHIFT;
      end
      if (sample_cnt >= warmup_q) begin
        for (int i = 0; i < NUM_AXES; i++) begin
          if (smooth_q[i] < min_q[i]) min_q[i] = smooth_q[i];
          if (smooth_q[i] > max_q[i]) max_q[i] = smooth_q[i];
        end
      end
    end
    // outputs stay zero until X has been tracked once
    if (min_q[0] <= max_q[0]) begin
      r.tracking = 1'b1;
      for (int i = 0; i < NUM_AXES; i++) begin
        lo   = min_q[i] >>> FRAC_SHIFT;
        hi   = max_q[i] >>> FRAC_SHIFT;
        bias = (lo + hi) >>> 1;
        r.low[i]    = lo[AXIS_BITS-1:0];
        r.high[i]   = hi[AXIS_BITS-1:0];
        r.offset[i] = bias[AXIS_BITS-1:0];
      end
    end
    return r;
  endfunction

  function automatic cal_result_t tracked(int lx, int hx, int ox, int ly, int hy, int oy,
                                          int lz, int hz, int oz);
    cal_result_t r;
    r.tracking  = 1'b1;
    r.low[0]    = AXIS_BITS'(lx);
    r.high[0]   = AXIS_BITS'(hx);
    r.offset[0] = AXIS_BITS'(ox);
    r.low[1]    = AXIS_BITS'(ly);
    r.high[1]   = AXIS_BITS'(hy);
    r.offset[1] = AXIS_BITS'(oy);
    r.low[2]    = AXIS_BITS'(lz);
    r.high[2]   = AXIS_BITS'(hz);
    r.offset[2] = AXIS_BITS'(oz);
    return r;
  endfunction

  function automatic stim_row_t cfg_row(logic [CFG_IDX_BITS-1:0] idx, int unsigned data);
    stim_row_t r;
    r          = '0;
    r.kind     = ROW_CFG;
    r.reg_idx  = idx;
    r.reg_data = CFG_DATA_BITS'(data);
    return r;
  endfunction

  function automatic stim_row_t free_row(int x, int y, int z);
    stim_row_t r;
    r           = '0;
    r.kind      = ROW_SAMPLE;
    r.sample[0] = AXIS_BITS'(x);
    r.sample[1] = AXIS_BITS'(y);
    r.sample[2] = AXIS_BITS'(z);
    return r;
  endfunction

  function automatic stim_row_t fixed_row(int x, int y, int z, cal_result_t want);
    stim_row_t r;
    r      = free_row(x, y, z);
    r.kind = ROW_CHECKED;
    r.want = want;
    return r;
  endfunction

  function automatic int unsigned draw_gap();
    return link_busy ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  // Mostly a narrow band around a center, with rare outliers; wide mode is full range
  function automatic logic [AXIS_BITS-1:0] draw_axis(int center, int unsigned spread, bit wide);
    int v;
    if (wide || $urandom_range(0, 31) == 0) begin
      case ($urandom_range(0, 7))
        0:       return 16'h8000;
        1:       return 16'h7fff;
        default: return AXIS_BITS'($urandom);
      endcase
    end
    v = center + int'($urandom_range(0, 2 * spread)) - int'(spread);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return AXIS_BITS'(v);
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= PRINT_CAP) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic check_result(input cal_result_t got, input cal_result_t want);
    string axis_tag;
    axis_tag = "xyz";
    if (got.tracking !== want.tracking)
      report_mismatch($sformatf("tracking_valid got %0b expected %0b",
                                got.tracking, want.tracking));
    for (int i = 0; i < NUM_AXES; i++) begin
      if (got.low[i] !== want.low[i])
        report_mismatch($sformatf("low_%c got %0d expected %0d", axis_tag[i],
                                  $signed(got.low[i]), $signed(want.low[i])));
      if (got.high[i] !== want.high[i])
        report_mismatch($sformatf("high_%c got %0d expected %0d", axis_tag[i],
                                  $signed(got.high[i]), $signed(want.high[i])));
      if (got.offset[i] !== want.offset[i])
        report_mismatch($sformatf("offset_%c got %0d expected %0d", axis_tag[i],
                                  $signed(got.offset[i]), $signed(want.offset[i])));
    end
  endtask

  // Lower valid and wait until every sample has produced its result
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Register write, only with the block idle; called at a falling edge
  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input int unsigned data);
    if (in_valid_i) drain_results();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= CFG_DATA_BITS'(data);
    if (idx == REG_FILTER_FACTOR) factor_q = FACTOR_BITS'(data);
    else if (idx == REG_WARMUP_COUNT) warmup_q = CNT_BITS'(data);
    @(negedge clk_i);
  endtask

  // One input beat; called at a falling edge and returns at a falling edge
  task automatic send_sample(input axis_triple_t s, input bit use_want, input cal_result_t want);
    int unsigned gap;
    cal_result_t model_out;
    gap = draw_gap();
    if (cfg_we_i) cfg_we_i <= 1'b0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    mag_x_i    <= s[0];
    mag_y_i    <= s[1];
    mag_z_i    <= s[2];
    do @(posedge clk_i); while (!in_ready_o);
    model_out = advance_calibrator(s);
    pending_results.push_back(use_want ? want : model_out);
    @(negedge clk_i);
  endtask

  // Result side: random stalls, one long hold-off on request, compare each beat
  initial begin : result_sink
    int unsigned stall;
    cal_result_t got;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      stall    = hold_req ? HOLD_CYCLES : draw_gap();
      hold_req = 1'b0;
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      got.tracking  = tracking_valid_o;
      got.low[0]    = low_x_o;
      got.high[0]   = high_x_o;
      got.offset[0] = offset_x_o;
      got.low[1]    = low_y_o;
      got.high[1]   = high_y_o;
      got.offset[1] = offset_y_o;
      got.low[2]    = low_z_o;
      got.high[2]   = high_z_o;
      got.offset[2] = offset_z_o;
      if (pending_results.size() == 0) report_mismatch("result beat with nothing expected");
      else check_result(got, pending_results.pop_front());
      @(negedge clk_i);
    end
  end

  initial begin : watchdog
    #(LIMIT_NS);
    $display("** mag_hard_iron_calibrator: FAILED **");
    $finish;
  end

  initial begin : stimulus
    stim_row_t    plan [$];
    int           center [NUM_AXES];
    int unsigned  spread;
    int unsigned  factor;
    int unsigned  warmup;
    axis_triple_t s;
    bit           wide;

    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = '0;
    cfg_wdata_i  = '0;
    in_valid_i   = 1'b0;
    mag_x_i      = '0;
    mag_y_i      = '0;
    mag_z_i      = '0;
    link_busy    = 1'b0;
    hold_req     = 1'b0;
    mismatch_cnt = 0;
    for (int i = 0; i < NUM_AXES; i++) begin
      smooth_q[i] = 0;
      min_q[i]    = STATE_MAX;
      max_q[i]    = STATE_MIN;
    end
    sample_cnt = '0;
    factor_q   = FILTER_FACTOR_RST;
    warmup_q   = WARMUP_COUNT_RST;

    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    // Warm-up at reset settings: nothing tracked yet, all fields zero
    plan.push_back(fixed_row(0, 0, 0, '0));
    plan.push_back(fixed_row(-32768, 32767, -1, '0));
    plan.push_back(fixed_row(32767, -32768, 1, '0));
    plan.push_back(fixed_row(-21846, 21845, 0, '0));
    plan.push_back(fixed_row(21845, -21846, -32768, '0));
    // Counter already past a warm-up of one; zero factor passes samples straight through
    plan.push_back(cfg_row(REG_WARMUP_COUNT, 1));
    plan.push_back(cfg_row(REG_FILTER_FACTOR, 0));
    plan.push_back(fixed_row(100, -200, 300, tracked(100, 100, 100, -200, -200, -200,
                                                     300, 300, 300)));
    plan.push_back(fixed_row(101, -199, 299, tracked(100, 101, 100, -200, -199, -200,
                                                     299, 300, 299)));
    plan.push_back(fixed_row(99, -201, 300, tracked(99, 101, 100, -201, -199, -200,
                                                    299, 300, 299)));
    // Half weight, then the heaviest weight with extreme samples
    plan.push_back(cfg_row(REG_FILTER_FACTOR, 32768));
    plan.push_back(free_row(200, -100, 0));
    plan.push_back(free_row(-5, -5, -5));
    plan.push_back(free_row(7, 3, -3));
    plan.push_back(cfg_row(REG_FILTER_FACTOR, 65535));
    plan.push_back(free_row(32767, 32767, 32767));
    plan.push_back(free_row(-32768, -32768, -32768));
    // Warm-up of zero behaves as one
    plan.push_back(cfg_row(REG_WARMUP_COUNT, 0));
    plan.push_back(free_row(1, 2, 3));
    plan.push_back(free_row(-1, -2, -3));
    // Raised warm-up pauses tracking while the counter climbs, then resumes
    plan.push_back(cfg_row(REG_WARMUP_COUNT, 65535));
    plan.push_back(free_row(40, 40, 40));
    plan.push_back(cfg_row(REG_WARMUP_COUNT, 6));
    plan.push_back(free_row(-9000, 9000, 12));
    plan.push_back(free_row(9000, -9000, -12));

    foreach (plan[k]) begin
      if (plan[k].kind == ROW_CFG) write_reg(plan[k].reg_idx, plan[k].reg_data);
      else send_sample(plan[k].sample, plan[k].kind == ROW_CHECKED, plan[k].want);
    end

    // Random phases: each one a register setting and a cluster of samples
    for (int p = 0; p < PHASES; p++) begin
      wide      = (p == PHASES - 1);
      link_busy = (p % 4 == 2);
      if (p == 0) factor = 65535;
      else if (p == 1) factor = 0;
      else if (wide) factor = $urandom_range(0, 8192);
      else factor = $urandom_range(0, 65535);
      if (p == 1) warmup = 65535;
      else if (p == 3) warmup = 0;
      else if (wide) warmup = 1;
      else warmup = $urandom_range(1, 400);
      write_reg(REG_FILTER_FACTOR, factor);
      write_reg(REG_WARMUP_COUNT, warmup);
      // long result-side hold-off while samples keep coming
      if (p == 2 || p == 6) hold_req = 1'b1;
      for (int a = 0; a < NUM_AXES; a++) center[a] = int'($urandom_range(0, 40000)) - 20000;
      spread = 1 << $urandom_range(0, 12);
      for (int n = 0; n < PHASE_BEATS; n++) begin
        for (int a = 0; a < NUM_AXES; a++) s[a] = draw_axis(center[a], spread, wide);
        send_sample(s, 1'b0, '0);
      end
    end

    drain_results();
    repeat (10) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("** mag_hard_iron_calibrator: PASSED **");
    end else begin
      $display("** mag_hard_iron_calibrator: FAILED **");
    end
    $finish;
  end

endmodule
